// ===== hw/rtl/differential_drive_command_mixer_core_macros.svh =====
// Assertion helpers shared by the mixer RTL.
// Each expects clk_i and rst_ni in the scope of use.
`ifndef DIFFERENTIAL_DRIVE_COMMAND_MIXER_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_COMMAND_MIXER_CORE_MACROS_SVH

// Invariant checked at every edge out of reset.
`define DDCM_ASSERT(label_, prop_, msg_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop_)) \
    else $error(msg_);

// Same-cycle implication.
`define DDCM_ASSERT_IMP(label_, ante_, cons_, msg_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |-> (cons_)) \
    else $error(msg_);

// Next-cycle implication.
`define DDCM_ASSERT_NEXT(label_, ante_, cons_, msg_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |=> (cons_)) \
    else $error(msg_);

`endif

// ===== hw/rtl/ddcm_pkg.sv =====
package ddcm_pkg;

  localparam int unsigned PulseW = 11;
  localparam int unsigned SpeedW = 13;

  localparam logic [PulseW-1:0] PulseMin  = 11'd1100;
  localparam logic [PulseW-1:0] PulseMax  = 11'd1900;
  localparam logic [PulseW-1:0] YawCentre = 11'd1500;

  localparam logic [11:0] KeyScale  = 12'd3840;
  localparam logic [11:0] PlanScale = 12'd1920;

  // x / 5 == (x * 52429) >> 18, exact for x below 2^18
  localparam logic [15:0] RecipFifth = 16'd52429;
  localparam int unsigned RecipShift = 18;

  // square root of a 26-bit value shifted up by 32: 29 result bits, one per step
  localparam int unsigned RootW     = 29;
  localparam int unsigned RootSteps = 29;
  localparam int unsigned DivSteps  = 12;
  localparam int unsigned StepCntW  = 5;

  localparam logic [29:0] OneQ16 = 30'h0001_0000;

  typedef struct packed {
    logic              planner;
    logic              mix_en;
    logic [PulseW-1:0] yaw;
    logic [PulseW-1:0] throttle;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle,
    StAngle,
    StMix,
    StSquare,
    StRoot,
    StDivSet,
    StDivide,
    StDone
  } back_state_e;

endpackage

// ===== hw/rtl/ddcm_front.sv =====
module ddcm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic signed [15:0]  throttle_value_i,
  input  logic signed [15:0]  roll_value_i,
  output logic                push_o,
  output ddcm_pkg::cmd_t      cmd_o,
  input  logic                full_i
);

  function automatic logic [ddcm_pkg::PulseW-1:0] clamp_pulse(input logic signed [17:0] v);
    logic [ddcm_pkg::PulseW-1:0] r;
    if (v < $signed({7'd0, ddcm_pkg::PulseMin})) begin
      r = ddcm_pkg::PulseMin;
    end else if (v > $signed({7'd0, ddcm_pkg::PulseMax})) begin
      r = ddcm_pkg::PulseMax;
    end else begin
      r = v[ddcm_pkg::PulseW-1:0];
    end
    return r;
  endfunction

  logic [ddcm_pkg::PulseW-1:0] yaw_q, yaw_d;
  logic [ddcm_pkg::PulseW-1:0] thr_q, thr_d;
  logic                        mode_q;
  logic                        accept;
  logic signed [17:0]          thr_ext, rol_ext, thr_sum, rol_sum;
  logic                        chord;

  assign accept     = in_valid_i & ~full_i;
  assign in_ready_o = ~full_i;

  always_comb begin
    thr_ext = {{2{throttle_value_i[15]}}, throttle_value_i};
    rol_ext = {{2{roll_value_i[15]}}, roll_value_i};
    thr_sum = $signed({7'd0, thr_q}) + thr_ext;
    rol_sum = $signed({7'd0, yaw_q}) + rol_ext;
    chord   = (throttle_value_i == 16'hFFFF) && (roll_value_i == 16'hFFFF);
    if (kind_i) begin
      thr_d = clamp_pulse(thr_ext);
      yaw_d = clamp_pulse(rol_ext);
    end else if (chord) begin
      // both deltas at -1: back to centre yaw and idle throttle
      thr_d = ddcm_pkg::PulseMin;
      yaw_d = ddcm_pkg::YawCentre;
    end else begin
      thr_d = clamp_pulse(thr_sum);
      yaw_d = clamp_pulse(rol_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q  <= ddcm_pkg::YawCentre;
      thr_q  <= ddcm_pkg::PulseMin;
      mode_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (accept) begin
        yaw_q <= yaw_d;
        thr_q <= thr_d;
      end
    end
  end

  assign push_o         = accept;
  assign cmd_o.planner  = kind_i;
  assign cmd_o.mix_en   = ~mode_q;
  assign cmd_o.yaw      = yaw_d;
  assign cmd_o.throttle = thr_d;

endmodule

// ===== hw/rtl/ddcm_queue.sv =====
`include "differential_drive_command_mixer_core_macros.svh"

module ddcm_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ddcm_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output ddcm_pkg::cmd_t cmd_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  ddcm_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `DDCM_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count beyond depth")
  `DDCM_ASSERT_IMP(a_no_pop_empty, pop_i, !empty_o, "pop from empty queue")
  `DDCM_ASSERT_IMP(a_no_push_full, push_i, !full_o, "push into full queue")

endmodule

// ===== hw/rtl/ddcm_back.sv =====
`include "differential_drive_command_mixer_core_macros.svh"

module ddcm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddcm_pkg::cmd_t     cmd_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [12:0] left_speed_o,
  output logic signed [12:0] right_speed_o,
  output logic [10:0]        yaw_out_o,
  output logic [10:0]        throttle_out_o
);

  localparam int unsigned RemW = ddcm_pkg::RootW + 1;

  ddcm_pkg::back_state_e state_q, state_d;
  ddcm_pkg::cmd_t        cur_q;

  logic [ddcm_pkg::StepCntW-1:0] cnt_q;
  logic [10:0]                   a_mag_q;
  logic                          a_neg_q;
  logic [9:0]                    td_q;
  logic [11:0]                   mag1_q, mag2_q;
  logic                          neg1_q, neg2_q;
  logic [25:0]                   rad_q;
  logic [ddcm_pkg::RootW-1:0]    root_q;
  logic [RemW-1:0]               rem_q;
  logic [29:0]                   den_q;
  logic [29:0]                   drem1_q, drem2_q;
  logic [11:0]                   quot1_q, quot2_q;

  // angle step
  logic signed [11:0] yd;
  logic [11:0]        ymag;
  logic [13:0]        y24;
  logic [29:0]        a_prod;
  // mix step
  logic [13:0]        a5_mag, t12;
  logic signed [15:0] a5s, v1, v2;
  logic [14:0]        v1mag, v2mag;
  logic [30:0]        p1, p2;
  // square step
  logic [23:0]        s1, s2;
  logic [24:0]        sq;
  // root step
  logic [31:0]        rem_sh, trial;
  logic               root_ge;
  // divide step
  logic [11:0]        scale;
  logic [23:0]        n1, n2;
  logic [30:0]        sh1, sh2, den_ext;
  logic               ge1, ge2;
  logic               last_root, last_div;
  logic               quot_ok;

  always_comb begin
    yd     = $signed({1'b0, cur_q.yaw}) - $signed({1'b0, ddcm_pkg::YawCentre});
    ymag   = yd[11] ? 12'(-yd) : 12'(yd);
    y24    = 14'(ymag[8:0]) * 14'd24;
    a_prod = 30'(y24) * 30'(ddcm_pkg::RecipFifth);

    a5_mag = 14'(a_mag_q) * 14'd5;
    t12    = 14'(td_q) * 14'd12;
    a5s    = a_neg_q ? -$signed({2'b00, a5_mag}) : $signed({2'b00, a5_mag});
    v1     = $signed({2'b00, t12}) + a5s;
    v2     = $signed({2'b00, t12}) - a5s;
    v1mag  = v1[15] ? 15'(-v1) : 15'(v1);
    v2mag  = v2[15] ? 15'(-v2) : 15'(v2);
    p1     = 31'(v1mag) * 31'(ddcm_pkg::RecipFifth);
    p2     = 31'(v2mag) * 31'(ddcm_pkg::RecipFifth);

    s1 = mag1_q * mag1_q;
    s2 = mag2_q * mag2_q;
    sq = {1'b0, s1} + {1'b0, s2};

    rem_sh  = {rem_q, rad_q[25:24]};
    trial   = {1'b0, root_q, 2'b01};
    root_ge = (rem_sh >= trial);

    scale   = cur_q.planner ? ddcm_pkg::PlanScale : ddcm_pkg::KeyScale;
    n1      = mag1_q * scale;
    n2      = mag2_q * scale;
    den_ext = {1'b0, den_q};
    sh1     = {drem1_q, 1'b0};
    sh2     = {drem2_q, 1'b0};
    ge1     = (sh1 >= den_ext);
    ge2     = (sh2 >= den_ext);

    last_root = (cnt_q == ddcm_pkg::StepCntW'(ddcm_pkg::RootSteps - 1));
    last_div  = (cnt_q == ddcm_pkg::StepCntW'(ddcm_pkg::DivSteps - 1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ddcm_pkg::StIdle: begin
        if (!empty_i) begin
          state_d = cmd_i.mix_en ? ddcm_pkg::StAngle : ddcm_pkg::StDone;
        end
      end
      ddcm_pkg::StAngle:  state_d = ddcm_pkg::StMix;
      ddcm_pkg::StMix:    state_d = ddcm_pkg::StSquare;
      ddcm_pkg::StSquare: state_d = ddcm_pkg::StRoot;
      ddcm_pkg::StRoot: begin
        if (last_root) begin
          state_d = ddcm_pkg::StDivSet;
        end
      end
      ddcm_pkg::StDivSet: state_d = ddcm_pkg::StDivide;
      ddcm_pkg::StDivide: begin
        if (last_div) begin
          state_d = ddcm_pkg::StDone;
        end
      end
      ddcm_pkg::StDone: begin
        if (out_ready_i) begin
          state_d = ddcm_pkg::StIdle;
        end
      end
      default: state_d = ddcm_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ddcm_pkg::StIdle: pop_o       = ~empty_i;
      ddcm_pkg::StDone: out_valid_o = 1'b1;
      default: begin
        pop_o       = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddcm_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ddcm_pkg::StRoot || state_q == ddcm_pkg::StDivide) begin
        cnt_q <= (state_d == state_q) ? cnt_q + ddcm_pkg::StepCntW'(1) : '0;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ddcm_pkg::StIdle: begin
        if (!empty_i) begin
          cur_q   <= cmd_i;
          quot1_q <= '0;
          quot2_q <= '0;
          neg1_q  <= 1'b0;
          neg2_q  <= 1'b0;
        end
      end
      ddcm_pkg::StAngle: begin
        a_mag_q <= a_prod[ddcm_pkg::RecipShift+10:ddcm_pkg::RecipShift];
        a_neg_q <= yd[11] ^ cur_q.planner;
        td_q    <= 10'(cur_q.throttle - ddcm_pkg::PulseMin);
      end
      ddcm_pkg::StMix: begin
        mag1_q <= p1[ddcm_pkg::RecipShift+11:ddcm_pkg::RecipShift];
        mag2_q <= p2[ddcm_pkg::RecipShift+11:ddcm_pkg::RecipShift];
        neg1_q <= v1[15];
        neg2_q <= v2[15];
      end
      ddcm_pkg::StSquare: begin
        rad_q  <= {1'b0, sq};
        root_q <= '0;
        rem_q  <= '0;
      end
      ddcm_pkg::StRoot: begin
        rad_q <= {rad_q[23:0], 2'b00};
        if (root_ge) begin
          rem_q  <= RemW'(rem_sh - trial);
          root_q <= {root_q[ddcm_pkg::RootW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh[RemW-1:0];
          root_q <= {root_q[ddcm_pkg::RootW-2:0], 1'b0};
        end
      end
      ddcm_pkg::StDivSet: begin
        den_q   <= {1'b0, root_q} + ddcm_pkg::OneQ16;
        drem1_q <= {2'b00, n1, 4'b0000};
        drem2_q <= {2'b00, n2, 4'b0000};
        quot1_q <= '0;
        quot2_q <= '0;
      end
      ddcm_pkg::StDivide: begin
        drem1_q <= ge1 ? 30'(sh1 - den_ext) : sh1[29:0];
        drem2_q <= ge2 ? 30'(sh2 - den_ext) : sh2[29:0];
        quot1_q <= {quot1_q[10:0], ge1};
        quot2_q <= {quot2_q[10:0], ge2};
      end
      default: begin
      end
    endcase
  end

  assign left_speed_o   = neg1_q ? -$signed({1'b0, quot1_q}) : $signed({1'b0, quot1_q});
  assign right_speed_o  = neg2_q ? -$signed({1'b0, quot2_q}) : $signed({1'b0, quot2_q});
  assign yaw_out_o      = cur_q.yaw;
  assign throttle_out_o = cur_q.throttle;

  assign quot_ok = (quot1_q <= ddcm_pkg::KeyScale) && (quot2_q <= ddcm_pkg::KeyScale);

  `DDCM_ASSERT_IMP(a_quot_bound, out_valid_o, quot_ok, "speed beyond full scale")
  `DDCM_ASSERT_NEXT(a_pop_leaves_idle, pop_o, state_q != ddcm_pkg::StIdle, "pop did not start work")
  `DDCM_ASSERT_NEXT(a_result_held, out_valid_o && !out_ready_i, out_valid_o, "result withdrawn")

endmodule

// ===== hw/rtl/differential_drive_command_mixer_core.sv =====
// Motor mode: an accepted command passes through the queue, then the back end's
// angle, mix and square steps, the 29-step square root and the 12-step restoring
// dividers. Pass-through: it goes from the queue straight to the result registers.
// In both modes the back end takes no new command until the sink takes its result.
// The input side keeps accepting until the command queue (QueueDepth) fills.
// Reset (rst_ni low, asynchronous): yaw 1500, throttle 1100, motor mode, queue empty.
module differential_drive_command_mixer_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration: output_mode
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  // command input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic signed [15:0] throttle_value_i,
  input  logic signed [15:0] roll_value_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [12:0] left_speed_o,
  output logic signed [12:0] right_speed_o,
  output logic [10:0]        yaw_out_o,
  output logic [10:0]        throttle_out_o
);

  // Front end: pulse state update (clamp, reset chord) done at acceptance,
  // so each queued command already carries the pulses after its transaction.
  ddcm_pkg::cmd_t push_cmd, pop_cmd;
  logic           push, pop, q_full, q_empty;

  ddcm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .throttle_value_i (throttle_value_i),
    .roll_value_i     (roll_value_i),
    .push_o           (push),
    .cmd_o            (push_cmd),
    .full_i           (q_full)
  );

  // Short command queue decoupling the two halves.
  ddcm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .empty_o (q_empty)
  );

  // Back end: mixing, Q13.16 magnitude via digit-recurrence square root,
  // then normalise and scale through two restoring dividers run side by side.
  // The result is held in its own registers until the sink takes it.
  ddcm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (pop_cmd),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_speed_o   (left_speed_o),
    .right_speed_o  (right_speed_o),
    .yaw_out_o      (yaw_out_o),
    .throttle_out_o (throttle_out_o)
  );

endmodule
